// ===== src/lpsm_pkg.sv =====
// Package for the LRU page swap manager: sizes, field widths, status and
// register codes, and the request and result transfer structs.
// No dependencies.
`default_nettype none

package lpsm_pkg;

	// Sizes of the page table and the RAM slot table.
	localparam int NUM_PAGES = 256;
	localparam int RAM_SLOTS = 64;

	localparam int PAGE_W = 8;
	localparam int SLOT_W = 6;
	localparam int DCNT_W = 9;
	localparam int USE_W = 16;
	// Page map entry: on-disk flag over an 8-bit slot or disk index.
	localparam int PM_W = 9;
	// Clean copy entry: valid flag over an 8-bit disk slot.
	localparam int COPY_W = 9;
	// Slot table entry: usage stamp over clean copy.
	localparam int SE_W = USE_W + COPY_W;

	// Operation codes.
	localparam logic OP_SWAP_IN = 1'b0;
	localparam logic OP_ALLOC = 1'b1;

	// Status codes.
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_RESIDENT = 2'd1;
	localparam logic [1:0] STAT_UNMAPPED = 2'd2;
	localparam logic [1:0] STAT_DISK_FULL = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_SLOTS_IN_RAM = 2'd0;
	localparam logic [1:0] REG_RESERVED = 2'd1;
	localparam logic [1:0] REG_FREEZE = 2'd2;

	typedef struct packed {
		logic op;
		logic [7:0] page;
	} req_t;

	typedef struct packed {
		logic [5:0] ram_slot;
		logic evicted;
		logic [7:0] evicted_page;
		logic victim_written;
		logic [7:0] write_disk_slot;
		logic [7:0] read_disk_slot;
		logic [1:0] status;
	} rsp_t;

endpackage

`default_nettype wire

// ===== src/lru_page_swap_manager.sv =====
// LRU page swap manager. A resident page is answered from the page map lookup alone;
// otherwise the result waits on the scans of the slot table and of the page map, which
// read one entry a cycle.
// One request at a time: busy is high from the accepted transfer until the result
// strobe; the result is shown for one cycle on done and cannot be stalled.
// After reset, busy stays high while a clearing pass zeroes both tables.
`default_nettype none

module lru_page_swap_manager
	import lpsm_pkg::*;
#(
	parameter int NPAGES = NUM_PAGES,
	parameter int NSLOTS = RAM_SLOTS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire req_t req,
	output logic done,
	output rsp_t rsp,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_addr,
	input wire logic [6:0] cfg_wdata
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_LOOK = 8'b00000010,
		S_SCAN = 8'b00000100,
		S_PSCAN = 8'b00001000,
		S_COPY = 8'b00010000,
		S_FIN = 8'b00100000,
		S_RSP = 8'b01000000,
		S_CLR = 8'b10000000
	} state_t;

	localparam logic [USE_W:0] NO_STAMP = {1'b1, {USE_W{1'b0}}};

	state_t state_q, state_d;
	logic [6:0] slots_q;
	logic [SLOT_W-1:0] resv_q;
	logic freeze_q;

	logic op_q, op_d;
	logic [PAGE_W-1:0] page_q, page_d;
	logic [7:0] dslot_q, dslot_d;
	logic [SLOT_W-1:0] best_q, best_d;
	logic [USE_W:0] use_q, use_d;
	logic [SLOT_W-1:0] idx_s1, idx_d;
	logic [PAGE_W-1:0] pidx_s1, pidx_d;
	logic [PAGE_W-1:0] pg_q, pg_d;
	logic [USE_W-1:0] clock_q, clock_d;
	logic [DCNT_W-1:0] dcnt_q, dcnt_d;
	logic [PAGE_W-1:0] clr_q, clr_d;
	logic ev_q, ev_d;
	logic wr_q, wr_d;
	logic [7:0] wslot_q, wslot_d;
	rsp_t rsp_q, rsp_d;
	logic done_q, done_d;

	logic pm_we;
	logic [PAGE_W-1:0] pm_waddr, pm_raddr;
	logic [PM_W-1:0] pm_wdata, pm_rdata;
	logic slot_we;
	logic [SLOT_W-1:0] slot_waddr, slot_raddr;
	logic [SE_W-1:0] slot_wdata, slot_rdata;

	logic [SLOT_W-1:0] top_slot;
	logic begin_scan, begin_pscan;
	logic [USE_W:0] cur_use;
	logic [COPY_W-1:0] cur_copy;
	logic [USE_W:0] new_use;
	logic [SLOT_W-1:0] new_best;

	// Page map and slot table memories.
	lpsm_mem #(.DEPTH(NPAGES), .WIDTH(PM_W)) u_page_map (
		.clk(clk), .we(pm_we), .waddr(pm_waddr),
		.wdata(pm_wdata), .raddr(pm_raddr), .rdata(pm_rdata)
	);

	lpsm_mem #(.DEPTH(NSLOTS), .WIDTH(SE_W)) u_slot_tab (
		.clk(clk), .we(slot_we), .waddr(slot_waddr),
		.wdata(slot_wdata), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	// Highest slot in use, with the slot count saturated to 1..NSLOTS.
	always_comb begin
		if (slots_q == 7'd0) begin
			top_slot = '0;
		end else if (32'(slots_q) > NSLOTS) begin
			top_slot = SLOT_W'(NSLOTS - 1);
		end else begin
			top_slot = SLOT_W'(slots_q - 7'd1);
		end
	end

	assign cur_use = {1'b0, slot_rdata[SE_W-1:COPY_W]};
	assign cur_copy = slot_rdata[COPY_W-1:0];

	// Running minimum over the slot scan; the higher slot wins a tie.
	always_comb begin
		if (cur_use < use_q) begin
			new_use = cur_use;
			new_best = idx_s1;
		end else begin
			new_use = use_q;
			new_best = best_q;
		end
	end

	// Sequencer: next state, memory accesses and the result.
	always_comb begin
		state_d = state_q;
		op_d = op_q;
		page_d = page_q;
		dslot_d = dslot_q;
		best_d = best_q;
		use_d = use_q;
		idx_d = idx_s1;
		pidx_d = pidx_s1;
		pg_d = pg_q;
		clock_d = clock_q;
		dcnt_d = dcnt_q;
		clr_d = clr_q;
		ev_d = ev_q;
		wr_d = wr_q;
		wslot_d = wslot_q;
		rsp_d = rsp_q;
		done_d = 1'b0;
		begin_scan = 1'b0;
		begin_pscan = 1'b0;
		pm_raddr = req.page;
		pm_we = 1'b0;
		pm_waddr = page_q;
		pm_wdata = '0;
		slot_raddr = idx_s1 - SLOT_W'(1);
		slot_we = 1'b0;
		slot_waddr = best_q;
		slot_wdata = '0;

		case (state_q)
			S_CLR: begin
				// Zero one page map entry a cycle, and one slot table entry while the index is in range.
				pm_we = 1'b1;
				pm_waddr = clr_q;
				pm_wdata = '0;
				if (32'(clr_q) < NSLOTS) begin
					slot_we = 1'b1;
					slot_waddr = clr_q[SLOT_W-1:0];
					slot_wdata = '0;
				end
				clr_d = clr_q + PAGE_W'(1);
				if (clr_q == PAGE_W'(NPAGES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					op_d = req.op;
					page_d = req.page;
					dslot_d = '0;
					ev_d = 1'b0;
					wr_d = 1'b0;
					wslot_d = '0;
					if (req.op == OP_SWAP_IN) begin
						state_d = S_LOOK;
					end else begin
						begin_scan = 1'b1;
					end
				end
			end
			S_LOOK: begin
				if (!pm_rdata[PM_W-1]) begin
					rsp_d = '0;
					rsp_d.ram_slot = pm_rdata[SLOT_W-1:0];
					rsp_d.status = STAT_RESIDENT;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					dslot_d = pm_rdata[7:0];
					begin_scan = 1'b1;
				end
			end
			S_SCAN: begin
				use_d = new_use;
				best_d = new_best;
				if (new_use == '0) begin
					state_d = S_FIN;
				end else if (idx_s1 == resv_q) begin
					begin_pscan = 1'b1;
				end else begin
					idx_d = idx_s1 - SLOT_W'(1);
				end
			end
			S_PSCAN: begin
				pm_raddr = pidx_s1 + PAGE_W'(1);
				pidx_d = pidx_s1 + PAGE_W'(1);
				if (pm_rdata == {{(PM_W-SLOT_W){1'b0}}, best_q}) begin
					pg_d = pidx_s1;
					slot_raddr = best_q;
					state_d = S_COPY;
				end else if (pidx_s1 == PAGE_W'(NPAGES - 1)) begin
					rsp_d = '0;
					rsp_d.ram_slot = best_q;
					rsp_d.status = STAT_UNMAPPED;
					done_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_COPY: begin
				if (!cur_copy[COPY_W-1] && dcnt_q == DCNT_W'(NPAGES)) begin
					rsp_d = '0;
					rsp_d.ram_slot = best_q;
					rsp_d.status = STAT_DISK_FULL;
					done_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					ev_d = 1'b1;
					pm_we = 1'b1;
					pm_waddr = pg_q;
					if (cur_copy[COPY_W-1]) begin
						wslot_d = cur_copy[7:0];
						pm_wdata = {1'b1, cur_copy[7:0]};
					end else begin
						wr_d = 1'b1;
						wslot_d = dcnt_q[7:0];
						dcnt_d = dcnt_q + DCNT_W'(1);
						pm_wdata = {1'b1, dcnt_q[7:0]};
					end
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				// Map the page to the slot and stamp the slot.
				pm_we = 1'b1;
				pm_waddr = page_q;
				pm_wdata = {{(PM_W-SLOT_W){1'b0}}, best_q};
				slot_we = 1'b1;
				slot_waddr = best_q;
				if (op_q == OP_SWAP_IN) begin
					slot_wdata = {USE_W'(1), 1'b1, dslot_q};
				end else if (freeze_q) begin
					slot_wdata = '0;
				end else begin
					slot_wdata = {clock_q, {COPY_W{1'b0}}};
				end
				if (!freeze_q) begin
					clock_d = clock_q + USE_W'(1);
				end
				state_d = S_RSP;
			end
			S_RSP: begin
				rsp_d.ram_slot = best_q;
				rsp_d.evicted = ev_q;
				rsp_d.evicted_page = ev_q ? pg_q : '0;
				rsp_d.victim_written = wr_q;
				rsp_d.write_disk_slot = wslot_q;
				rsp_d.read_disk_slot = (op_q == OP_SWAP_IN) ? dslot_q : '0;
				rsp_d.status = STAT_OK;
				done_d = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Start of the victim scan, or straight to the page search when
		// the scan range is empty.
		if (begin_scan) begin
			best_d = top_slot;
			use_d = NO_STAMP;
			if (resv_q > top_slot) begin
				begin_pscan = 1'b1;
			end else begin
				slot_raddr = top_slot;
				idx_d = top_slot;
				state_d = S_SCAN;
			end
		end

		// Start of the search for the page mapped to the victim.
		if (begin_pscan) begin
			pm_raddr = '0;
			pidx_d = '0;
			state_d = S_PSCAN;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clock_q <= USE_W'(1);
			dcnt_q <= '0;
			clr_q <= '0;
			done_q <= 1'b0;
			slots_q <= 7'd64;
			resv_q <= SLOT_W'(1);
			freeze_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clock_q <= clock_d;
			dcnt_q <= dcnt_d;
			clr_q <= clr_d;
			done_q <= done_d;
			if (cfg_we) begin
				case (cfg_addr)
					REG_SLOTS_IN_RAM: slots_q <= cfg_wdata;
					REG_RESERVED: resv_q <= cfg_wdata[SLOT_W-1:0];
					REG_FREEZE: freeze_q <= cfg_wdata[0];
					default: ;
				endcase
			end
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		op_q <= op_d;
		page_q <= page_d;
		dslot_q <= dslot_d;
		best_q <= best_d;
		use_q <= use_d;
		idx_s1 <= idx_d;
		pidx_s1 <= pidx_d;
		pg_q <= pg_d;
		ev_q <= ev_d;
		wr_q <= wr_d;
		wslot_q <= wslot_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	// A result only follows a request at work.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request at work");

	// No eviction means no disk write is reported.
	a_no_ev_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.evicted) |-> (!rsp.victim_written && rsp.write_disk_slot == '0))
		else $error("disk write reported without an eviction");

	// The disk fill count never passes the table size.
	a_dcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(dcnt_q) <= NPAGES)
		else $error("disk fill count overflow");
`endif

endmodule

`default_nettype wire

// ===== src/lpsm_mem.sv =====
// Synchronous memory with one write and one registered read port.
// Contents are undefined until written; the top level clears it after reset.
// Depends on nothing but its parameters.
`default_nettype none

module lpsm_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 25
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] data_q;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		data_q <= mem[raddr];
	end

	assign rdata = data_q;

endmodule

`default_nettype wire
